@@ rtl/rss_pkg.sv @@
// Shared types and constants for the relay status response scanner.
// Holds the scan phase codes, character constants and the per-word item structs.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package rss_pkg;

   // Scan phase codes. Both modes share one 2-bit phase register.
   localparam logic [1:0] PH_START   = 2'd0;  // line start (mode 0), tag search (mode 1)
   localparam logic [1:0] PH_SEVENTH = 2'd1;  // mode 0: seventh character of a status line
   localparam logic [1:0] PH_STATUS  = 2'd2;  // mode 0: inside the status bit string
   localparam logic [1:0] PH_SKIP    = 2'd3;  // mode 0: skipping to the next line
   localparam logic [1:0] PH_DIGIT   = 2'd1;  // mode 1: next byte is the relay digit
   localparam logic [1:0] PH_HASH    = 2'd2;  // mode 1: seeking the colour marker
   localparam logic [1:0] PH_COLOUR  = 2'd3;  // mode 1: comparing the colour code

   // Board modes.
   localparam logic MODE_STATUS = 1'b0;
   localparam logic MODE_TAGS   = 1'b1;

   // Characters of interest.
   localparam logic [7:0] CHAR_NUL   = 8'h00;
   localparam logic [7:0] CHAR_NL    = 8'h0A;
   localparam logic [7:0] CHAR_HASH  = 8'h23;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_ONE   = 8'h31;
   localparam logic [7:0] CHAR_EIGHT = 8'h38;
   localparam logic [7:0] CHAR_R     = 8'h52;

   // Lengths of the matched words.
   localparam logic [2:0] STATUS_LEN = 3'd6;
   localparam logic [2:0] TAG_LEN    = 3'd7;
   localparam logic [2:0] COLOUR_LEN = 3'd6;

   // One input word as seen by the scan core.
   typedef struct packed {
      logic       last;
      logic [7:0] resp_byte;
   } rss_item_type;

   // Scan core answer for the word presented to it.
   typedef struct packed {
      logic       done;
      logic [7:0] relay_mask;
   } rss_result_type;

   // Characters of "Status".
   function automatic logic [7:0] status_char(input logic [2:0] pos);
      logic [7:0] c;
      unique case (pos)
         3'd0:    c = 8'h53;
         3'd1:    c = 8'h74;
         3'd2:    c = 8'h61;
         3'd3:    c = 8'h74;
         3'd4:    c = 8'h75;
         3'd5:    c = 8'h73;
         default: c = CHAR_NUL;
      endcase
      return c;
   endfunction

   // Characters of "Relay-0".
   function automatic logic [7:0] tag_char(input logic [2:0] pos);
      logic [7:0] c;
      unique case (pos)
         3'd0:    c = 8'h52;
         3'd1:    c = 8'h65;
         3'd2:    c = 8'h6C;
         3'd3:    c = 8'h61;
         3'd4:    c = 8'h79;
         3'd5:    c = 8'h2D;
         3'd6:    c = 8'h30;
         default: c = CHAR_NUL;
      endcase
      return c;
   endfunction

   // Characters of "FF0000".
   function automatic logic [7:0] colour_char(input logic [2:0] pos);
      logic [7:0] c;
      unique case (pos)
         3'd0, 3'd1:             c = 8'h46;
         3'd2, 3'd3, 3'd4, 3'd5: c = CHAR_ZERO;
         default:                c = CHAR_NUL;
      endcase
      return c;
   endfunction

endpackage

`default_nettype wire

@@ rtl/rss_core.sv @@
// Scan core: board mode register, scan state registers and the one-word update.
// Depends on rss_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rss_core
   import rss_pkg::*;
#(
   parameter int RELAY_COUNT = 8
) (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           csr_wen,
   input  wire logic           csr_wdata,
   input  wire logic           step_en,
   input  wire rss_item_type   item,
   output rss_result_type      result
);

   localparam int CNT_W = $clog2(RELAY_COUNT + 1);
   localparam logic [CNT_W-1:0] RELAY_MAX = CNT_W'(RELAY_COUNT);

   logic             mode_ff;
   logic [1:0]       phase_ff, phase_in;
   logic [2:0]       pos_ff, pos_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [7:0]       mask_ff, mask_in;
   logic [7:0]       digit_ff, digit_in;
   logic             differs_ff, differs_in;
   logic             done_ff, done_in;
   logic             item_end;
   logic [7:0]       final_mask;

   // Bit of the relay named by an ASCII digit, zero when the digit is out of range.
   function automatic logic [7:0] digit_bit(input logic [7:0] d);
      logic [7:0] idx;
      logic [7:0] bits;
      idx  = d - CHAR_ONE;
      bits = '0;
      if (d >= CHAR_ONE && d <= CHAR_EIGHT && idx < 8'(RELAY_COUNT)) begin
         bits = 8'd1 << idx[2:0];
      end
      return bits;
   endfunction

   assign item_end = item.last || (item.resp_byte == CHAR_NUL);

   always_comb begin
      logic [7:0] b;
      b          = item.resp_byte;
      phase_in   = phase_ff;
      pos_in     = pos_ff;
      count_in   = count_ff;
      mask_in    = mask_ff;
      digit_in   = digit_ff;
      differs_in = differs_ff;
      done_in    = done_ff;

      if (b != CHAR_NUL) begin
         if (mode_ff == MODE_STATUS) begin
            if (!done_ff) begin
               unique case (phase_ff)
                  PH_START: begin
                     if (b == CHAR_NL) begin
                        pos_in = '0;
                     end else if (pos_ff < STATUS_LEN && b == status_char(pos_ff)) begin
                        pos_in = pos_ff + 3'd1;
                        if (pos_in == STATUS_LEN) begin
                           phase_in = PH_SEVENTH;
                        end
                     end else begin
                        phase_in = PH_SKIP;
                     end
                  end
                  PH_SEVENTH: begin
                     if (b == CHAR_NL) begin
                        phase_in = PH_START;
                        pos_in   = '0;
                     end else begin
                        phase_in = PH_STATUS;
                     end
                  end
                  PH_STATUS: begin
                     if (b == CHAR_NL) begin
                        done_in = 1'b1;
                     end else if (b == CHAR_ONE || b == CHAR_ZERO) begin
                        if (count_ff < RELAY_MAX) begin
                           if (b == CHAR_ONE) begin
                              mask_in = mask_ff | (8'd1 << count_ff);
                           end
                           count_in = count_ff + CNT_W'(1);
                        end
                     end
                  end
                  PH_SKIP: begin
                     if (b == CHAR_NL) begin
                        phase_in = PH_START;
                        pos_in   = '0;
                     end
                  end
               endcase
            end
         end else begin
            unique case (phase_ff)
               PH_START: begin
                  if (pos_ff < TAG_LEN && b == tag_char(pos_ff)) begin
                     pos_in = pos_ff + 3'd1;
                     if (pos_in == TAG_LEN) begin
                        phase_in = PH_DIGIT;
                        pos_in   = '0;
                     end
                  end else begin
                     pos_in = (b == CHAR_R) ? 3'd1 : 3'd0;
                  end
               end
               PH_DIGIT: begin
                  digit_in = b;
                  phase_in = PH_HASH;
               end
               PH_HASH: begin
                  if (b == CHAR_HASH) begin
                     phase_in   = PH_COLOUR;
                     pos_in     = '0;
                     differs_in = 1'b0;
                  end
               end
               PH_COLOUR: begin
                  if (pos_ff >= COLOUR_LEN || b != colour_char(pos_ff)) begin
                     differs_in = 1'b1;
                  end
                  pos_in = pos_ff + 3'd1;
                  if (pos_in >= COLOUR_LEN) begin
                     if (differs_in) begin
                        mask_in = mask_ff | digit_bit(digit_ff);
                     end
                     phase_in   = PH_START;
                     pos_in     = '0;
                     differs_in = 1'b0;
                  end
               end
            endcase
         end
      end

      // An early end after the relay digit counts as a colour mismatch.
      final_mask = mask_in;
      if (mode_ff == MODE_TAGS && (phase_in == PH_HASH || phase_in == PH_COLOUR)) begin
         final_mask = mask_in | digit_bit(digit_in);
      end
   end

   assign result.done       = item_end;
   assign result.relay_mask = final_mask;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff    <= MODE_STATUS;
         phase_ff   <= PH_START;
         pos_ff     <= '0;
         count_ff   <= '0;
         mask_ff    <= '0;
         digit_ff   <= '0;
         differs_ff <= 1'b0;
         done_ff    <= 1'b0;
      end else if (csr_wen || (step_en && item_end)) begin
         if (csr_wen) begin
            mode_ff <= csr_wdata;
         end
         phase_ff   <= PH_START;
         pos_ff     <= '0;
         count_ff   <= '0;
         mask_ff    <= '0;
         digit_ff   <= '0;
         differs_ff <= 1'b0;
         done_ff    <= 1'b0;
      end else if (step_en) begin
         phase_ff   <= phase_in;
         pos_ff     <= pos_in;
         count_ff   <= count_in;
         mask_ff    <= mask_in;
         digit_ff   <= digit_in;
         differs_ff <= differs_in;
         done_ff    <= done_in;
      end
   end

endmodule

`default_nettype wire

@@ rtl/relay_status_response_scanner.sv @@
// Top level of the relay status response scanner: input register, scan core, result register.
// Depends on rss_pkg and rss_core.
//
// Usage:
// The req_ channel carries one response character per word (tdata) and marks the
// final character of a response with tlast. A NUL character also ends a response
// and is not itself scanned. For every response one word leaves on the rsp_
// channel: an 8-bit mask in which bit k-1 is set when relay k is reported on.
// Words that do not end a response produce nothing on rsp_.
// The csr_ port writes the board mode (0: status-line bit string, 1: relay tags
// with colour codes). A write drops any scan in progress; write only while idle.
// Timing: an accepted word waits in the input register until it is scanned; a
// response-ending word's mask is registered as it is scanned and shown on rsp_.
// One word per cycle is sustained unless a response-ending word waits on a held
// result; the limit is the update of the scan state from one character.
// When the receiver stalls with a result still held, words that do not end a
// response keep flowing; only the next response-ending word waits in the input
// register, and req_tready drops once that register is also occupied.
// Reset clears the mode to 0, all scan state and the valid flags of both registers.
`timescale 1ns / 1ps
`default_nettype none

module relay_status_response_scanner
   import rss_pkg::*;
#(
   parameter int RELAY_COUNT = 8
) (
   input  wire logic       clock,
   input  wire logic       reset,
   // Configuration write port.
   input  wire logic       csr_wen,
   input  wire logic       csr_wdata,     // board_mode
   // Response characters in.
   input  wire logic       req_tvalid,
   output logic            req_tready,
   input  wire logic [7:0] req_tdata,     // [7:0] resp_byte
   input  wire logic       req_tlast,     // last
   // Relay masks out.
   output logic            rsp_tvalid,
   input  wire logic       rsp_tready,
   output logic [7:0]      rsp_tdata      // [7:0] relay_mask
);

   logic           in_valid_ff, in_valid_in;
   rss_item_type   item_ff;
   logic           rsp_valid_ff, rsp_valid_in;
   logic [7:0]     rsp_mask_ff;
   rss_result_type result;
   logic           out_free;
   logic           fire;

   rss_core #(
      .RELAY_COUNT(RELAY_COUNT)
   ) u_core (
      .clock    (clock),
      .reset    (reset),
      .csr_wen  (csr_wen),
      .csr_wdata(csr_wdata),
      .step_en  (fire),
      .item     (item_ff),
      .result   (result)
   );

   // The held word is scanned unless it ends a response and the result slot is busy.
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign fire       = in_valid_ff && (!result.done || out_free);
   assign req_tready = !in_valid_ff || fire;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_tvalid && req_tready) begin
         in_valid_in = 1'b1;
      end else if (fire) begin
         in_valid_in = 1'b0;
      end

      rsp_valid_in = rsp_valid_ff;
      if (fire && result.done) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers load on their handshakes and need no reset.
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         item_ff.resp_byte <= req_tdata;
         item_ff.last      <= req_tlast;
      end
      if (fire && result.done) begin
         rsp_mask_ff <= result.relay_mask;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_mask_ff;

   // A new result never lands on a held result that the receiver has not taken.
   a_no_overwrite : assert property (@(posedge clock) disable iff (reset)
      (fire && result.done) |-> out_free)
      else $error("result register overwritten while stalled");

   // A held input word is not lost or replaced while it waits.
   a_input_held : assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !fire) |=> (in_valid_ff && $stable(item_ff)))
      else $error("waiting input word was lost");

   // A result appears only after a response-ending word was scanned.
   a_result_source : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !$past(rsp_valid_ff) && !$past(reset))
         |-> $past(fire && result.done))
      else $error("result without a response-ending word");

   // Words that do not end a response are never held back by the output side.
   a_mid_flow : assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !result.done) |-> fire)
      else $error("mid-response word stalled");

endmodule

`default_nettype wire

@@ dv/tb_relay_status_response_scanner.sv @@
// Self-checking testbench for relay_status_response_scanner.
// Drives response text words, predicts each relay mask and checks it against rsp_.
// Depends on rss_pkg and the scanner RTL.
`timescale 1ns / 1ps

module tb_relay_status_response_scanner;
   import rss_pkg::*;

   localparam int RELAY_COUNT   = 8;
   // A taken word is scanned from the input register; its mask is then registered for rsp_.
   // The settle wait at the end of a drain therefore covers any word still in flight.
   localparam int SETTLE_CYCLES = 4;
   // Length of the deliberate receiver stall, and the watchdog limit on cycles in
   // which neither channel moves a word. The limit sits well above the longest
   // stall plus the longest sender gap.
   localparam int LONG_HOLD     = 200;
   localparam int QUIET_LIMIT   = 2000;

   // The three words that the scanner matches against, first character highest.
   localparam logic [55:0] STATUS_TXT = "Status";
   localparam logic [55:0] TAG_TXT    = "Relay-0";
   localparam logic [55:0] COLOUR_TXT = "FF0000";

   typedef enum int {READY_ALWAYS, READY_HALF, READY_MOSTLY, READY_PERIODIC} ready_style_type;

   logic       clock      = 1'b0;
   logic       reset      = 1'b1;
   logic       csr_wen    = 1'b0;
   logic       csr_wdata  = 1'b0;
   logic       req_tvalid = 1'b0;
   logic       req_tready;
   logic [7:0] req_tdata  = 8'h00;
   logic       req_tlast  = 1'b0;
   logic       rsp_tvalid;
   logic       rsp_tready = 1'b0;
   logic [7:0] rsp_tdata;

   // Masks that the scanner still owes, oldest first.
   logic [7:0] expected_masks[$];
   // Response text being assembled before it is sent.
   logic [7:0] frame_bytes[$];

   int  fail_count        = 0;
   int  quiet_cycles      = 0;
   int  words_sent        = 0;
   int  burst_left        = 0;
   bit  steady_sender     = 1'b0;
   bit  long_hold_request = 1'b0;

   // Shadow of the scanner: the mode register and the scan state.
   logic       board_mode_now;
   logic [1:0] scan_state;
   logic [3:0] match_len;
   logic [3:0] bits_taken;
   logic [7:0] relay_bits;
   logic [7:0] digit_seen;
   logic       colour_bad;
   logic       status_taken;

   always #10 clock = ~clock;

   relay_status_response_scanner #(
      .RELAY_COUNT(RELAY_COUNT)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .csr_wen    (csr_wen),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // ---------------------------------------------------------------------------
   // Mask prediction
   // ---------------------------------------------------------------------------

   // Character p of a matched word that is len characters long.
   function automatic logic [7:0] char_of(input logic [55:0] txt, input int len, input int p);
      return txt[8*(len-1-p) +: 8];
   endfunction

   // Every piece of scan state returns to zero after a mask and on a mode write.
   function automatic void clear_scan_state();
      scan_state   = PH_START;
      match_len    = '0;
      bits_taken   = '0;
      relay_bits   = '0;
      digit_seen   = '0;
      colour_bad   = 1'b0;
      status_taken = 1'b0;
   endfunction

   function automatic void light_relay(input int k);
      if (k < RELAY_COUNT && k < 8)
         relay_bits[k] = 1'b1;
   endfunction

   // Only digits '1' to '8' name a relay; anything else in the digit slot sets nothing.
   function automatic void light_digit_relay();
      if (digit_seen >= CHAR_ONE && digit_seen <= CHAR_EIGHT)
         light_relay(int'(digit_seen - CHAR_ONE));
   endfunction

   // Mode 0: find the first line that starts with "Status" and is longer than that,
   // skip its seventh character and take each '1' or '0' after it as the next relay.
   function automatic void scan_status_byte(input logic [7:0] b);
      if (status_taken)
         return;
      case (scan_state)
         PH_START: begin
            if (b == CHAR_NL) begin
               match_len = '0;
            end else if (match_len < STATUS_LEN &&
                         b == char_of(STATUS_TXT, int'(STATUS_LEN), int'(match_len))) begin
               match_len++;
               if (match_len == STATUS_LEN)
                  scan_state = PH_SEVENTH;
            end else begin
               scan_state = PH_SKIP;
            end
         end
         PH_SEVENTH: begin
            // A bare "Status" line is too short to count.
            if (b == CHAR_NL) begin
               scan_state = PH_START;
               match_len  = '0;
            end else begin
               scan_state = PH_STATUS;
            end
         end
         PH_STATUS: begin
            if (b == CHAR_NL) begin
               status_taken = 1'b1;
            end else if (b == CHAR_ONE || b == CHAR_ZERO) begin
               if (b == CHAR_ONE)
                  light_relay(int'(bits_taken));
               // The relay count saturates, so surplus characters set nothing.
               if (bits_taken < RELAY_COUNT)
                  bits_taken++;
            end
         end
         PH_SKIP: begin
            if (b == CHAR_NL) begin
               scan_state = PH_START;
               match_len  = '0;
            end
         end
      endcase
   endfunction

   // Mode 1: "Relay-0", a digit, anything up to '#', then six characters that must
   // read "FF0000"; any difference turns the digit's relay on.
   function automatic void scan_tag_byte(input logic [7:0] b);
      case (scan_state)
         PH_START: begin
            if (match_len < TAG_LEN &&
                b == char_of(TAG_TXT, int'(TAG_LEN), int'(match_len))) begin
               match_len++;
               if (match_len == TAG_LEN) begin
                  scan_state = PH_DIGIT;
                  match_len  = '0;
               end
            end else begin
               match_len = (b == CHAR_R) ? 4'd1 : 4'd0;
            end
         end
         PH_DIGIT: begin
            digit_seen = b;
            scan_state = PH_HASH;
         end
         PH_HASH: begin
            if (b == CHAR_HASH) begin
               scan_state = PH_COLOUR;
               match_len  = '0;
               colour_bad = 1'b0;
            end
         end
         PH_COLOUR: begin
            if (match_len >= COLOUR_LEN ||
                b != char_of(COLOUR_TXT, int'(COLOUR_LEN), int'(match_len)))
               colour_bad = 1'b1;
            match_len++;
            if (match_len >= COLOUR_LEN) begin
               if (colour_bad)
                  light_digit_relay();
               scan_state = PH_START;
               match_len  = '0;
               colour_bad = 1'b0;
            end
         end
      endcase
   endfunction

   // Runs one accepted word through the shadow and queues a mask when the response ends.
   // A NUL ends the response without being scanned; a word with tlast is scanned first.
   function automatic void predict_relay_mask(input logic [7:0] b, input logic l);
      if (b != CHAR_NUL) begin
         if (board_mode_now == MODE_TAGS)
            scan_tag_byte(b);
         else
            scan_status_byte(b);
      end
      if (l || b == CHAR_NUL) begin
         // Ending while seeking '#' or inside the colour counts as a mismatch.
         if (board_mode_now == MODE_TAGS && (scan_state == PH_HASH || scan_state == PH_COLOUR))
            light_digit_relay();
         expected_masks.push_back(relay_bits);
         clear_scan_state();
      end
   endfunction

   // ---------------------------------------------------------------------------
   // Response text builders
   // ---------------------------------------------------------------------------

   // Mostly printable filler, now and then any nonzero byte, never the banned one.
   function automatic logic [7:0] rand_junk(input logic [7:0] banned);
      logic [7:0] c;
      do begin
         if ($urandom_range(0, 5) == 0)
            c = 8'($urandom_range(1, 255));
         else
            c = 8'($urandom_range(32, 126));
      end while (c == banned);
      return c;
   endfunction

   function automatic void add_text(input string s);
      for (int i = 0; i < s.len(); i++)
         frame_bytes.push_back(s[i]);
   endfunction

   function automatic void add_junk(input int n, input logic [7:0] banned);
      for (int i = 0; i < n; i++)
         frame_bytes.push_back(rand_junk(banned));
   endfunction

   // A few leading lines, then usually one status line with a random bit string,
   // sometimes followed by a later status line that must be ignored.
   function automatic void build_status_frame();
      int pre_lines;
      int bit_chars;
      pre_lines = $urandom_range(0, 2);
      for (int i = 0; i < pre_lines; i++) begin
         if ($urandom_range(0, 3) == 0)
            add_text("Status");
         else if ($urandom_range(0, 2) == 0)
            add_text("Statu");
         else
            add_junk($urandom_range(0, 8), CHAR_NL);
         frame_bytes.push_back(CHAR_NL);
      end
      if ($urandom_range(0, 9) != 0) begin
         add_text("Status");
         add_junk(1, CHAR_NL);
         bit_chars = $urandom_range(0, 12);
         for (int i = 0; i < bit_chars; i++) begin
            if ($urandom_range(0, 9) < 7)
               frame_bytes.push_back(($urandom_range(0, 1) == 1) ? CHAR_ONE : CHAR_ZERO);
            else
               frame_bytes.push_back(rand_junk(CHAR_NL));
         end
         if ($urandom_range(0, 1) == 1) begin
            frame_bytes.push_back(CHAR_NL);
            if ($urandom_range(0, 1) == 1)
               add_text("Status 11111111");
         end
      end
   endfunction

   // Up to four relay tags with good or damaged colours; the last one may be cut short.
   function automatic void build_tag_frame();
      int         tags;
      bit         cut;
      logic [7:0] dropped;
      tags = $urandom_range(0, 4);
      cut  = 1'b0;
      for (int t = 0; t < tags && !cut; t++) begin
         if ($urandom_range(0, 1) == 1)
            add_junk($urandom_range(1, 5), CHAR_HASH);
         if ($urandom_range(0, 9) == 0)
            add_text("Relay-X");
         else
            add_text("Relay-0");
         if ($urandom_range(0, 5) == 0)
            frame_bytes.push_back(rand_junk(CHAR_NUL));
         else
            frame_bytes.push_back(CHAR_ONE + 8'($urandom_range(0, 7)));
         if (t == tags - 1 && $urandom_range(0, 4) == 0) begin
            cut = 1'b1;
         end else begin
            add_junk($urandom_range(0, 4), CHAR_HASH);
            frame_bytes.push_back(CHAR_HASH);
            add_text("FF0000");
            if ($urandom_range(0, 1) == 1)
               frame_bytes[frame_bytes.size() - 1 - $urandom_range(0, 5)] = rand_junk(CHAR_NUL);
            if (t == tags - 1 && $urandom_range(0, 5) == 0)
               repeat ($urandom_range(1, 5)) dropped = frame_bytes.pop_back();
         end
      end
   endfunction

   // Raw bytes of any value; a rare NUL inside splits the response in two.
   function automatic void build_noise_frame();
      int n;
      n = $urandom_range(1, 20);
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(0, 15) == 0)
            frame_bytes.push_back(CHAR_NUL);
         else
            frame_bytes.push_back(8'($urandom_range(1, 255)));
      end
   endfunction

   function automatic void build_frame_for_mode();
      if (board_mode_now == MODE_TAGS)
         build_tag_frame();
      else
         build_status_frame();
   endfunction

   // ---------------------------------------------------------------------------
   // Driving
   // ---------------------------------------------------------------------------

   // Offers one word and returns at the edge that takes it. The sender runs in bursts;
   // when a burst runs out it may drop tvalid for a random gap first, unless the sender is steady.
   task automatic send_word(input logic [7:0] word_byte, input logic word_last);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 32);
         if (!steady_sender && $urandom_range(0, 3) != 0) begin
            gap = $urandom_range(1, 6);
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tdata  <= word_byte;
      req_tlast  <= word_last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      words_sent++;
      predict_relay_mask(word_byte, word_last);
   endtask

   // Sends the assembled text as one response, ended by tlast on its final character
   // or by a trailing NUL. An empty text is just a NUL.
   task automatic send_frame(input logic nul_end);
      int n;
      n = frame_bytes.size();
      if (n == 0) begin
         send_word(CHAR_NUL, 1'($urandom_range(0, 1)));
      end else begin
         for (int i = 0; i < n; i++)
            send_word(frame_bytes[i], !nul_end && i == n - 1);
         if (nul_end)
            send_word(CHAR_NUL, 1'($urandom_range(0, 1)));
      end
      frame_bytes.delete();
   endtask

   task automatic send_text(input string s, input logic nul_end);
      frame_bytes.delete();
      add_text(s);
      send_frame(nul_end);
   endtask

   // Stops offering words, waits for every owed mask, then lets in-flight words settle.
   task automatic drain_results();
      req_tvalid <= 1'b0;
      burst_left = 0;
      while (expected_masks.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // The mode is only written with the scanner idle; the write also clears the scan.
   task automatic write_mode(input logic mode);
      drain_results();
      csr_wen   <= 1'b1;
      csr_wdata <= mode;
      @(posedge clock);
      csr_wen   <= 1'b0;
      board_mode_now = mode;
      clear_scan_state();
   endtask

   // ---------------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------------

   task automatic test_status_lines();
      write_mode(MODE_STATUS);
      send_text("Status:10110001\n", 1'b0);
      send_text("Status", 1'b1);                 // exactly "Status" is not a status line
      send_text("Status\nStatus 01\n", 1'b0);
      send_text("Status 1111111111", 1'b0);      // more bits than relays
      send_text("hello\nStatus-1x0y1\nStatus 11111111\n", 1'b1);  // later lines ignored
      send_text("xStatus 111\n", 1'b0);          // "Status" not at line start
      send_text("Stat\nStatus 0001", 1'b1);
      send_text("", 1'b0);                       // empty response
      frame_bytes.delete();
      frame_bytes.push_back(8'hFF);
      frame_bytes.push_back(8'h80);
      add_text("\nStatus 1");
      frame_bytes.push_back(8'hFF);
      send_frame(1'b0);
   endtask

   task automatic test_relay_tags();
      write_mode(MODE_TAGS);
      send_text("Relay-01#FF0000", 1'b0);        // matching colour, relay stays off
      send_text("Relay-03#FF0001", 1'b0);
      send_text("Relay-08 colour #00ff00", 1'b1);
      send_text("Relay-09#000000", 1'b0);        // digit out of range
      send_text("Relay-00#123456", 1'b0);
      send_text("Relay-0", 1'b1);                // ends before the digit
      send_text("Relay-05 abc", 1'b0);           // ends while seeking the marker
      send_text("Relay-06#FF", 1'b1);            // ends inside the colour
      send_text("RRelay-02#F00000", 1'b0);       // restart on a repeated 'R'
      send_text("Relay-01#000000Relay-07#FF0000Relay-02#ffffffRelay-04", 1'b0);
      send_text("Relay-0#FF0000", 1'b0);         // marker taken as the digit
      frame_bytes.delete();
      add_text("Relay-0");
      frame_bytes.push_back(8'hFF);
      add_text("#FF000");
      send_frame(1'b1);
   endtask

   // A mode write in the middle of a response throws away what was scanned so far.
   task automatic test_mode_write_drops_scan();
      frame_bytes.delete();
      add_text("Relay-04#00");
      foreach (frame_bytes[i]) send_word(frame_bytes[i], 1'b0);
      frame_bytes.delete();
      write_mode(MODE_TAGS);
      send_text("0000", 1'b0);
      write_mode(MODE_STATUS);
      frame_bytes.delete();
      add_text("Status 11");
      foreach (frame_bytes[i]) send_word(frame_bytes[i], 1'b0);
      frame_bytes.delete();
      write_mode(MODE_STATUS);
      send_text("11\n", 1'b0);
   endtask

   // The receiver stalls for a long stretch while short responses keep coming, so the
   // scanner fills up and holds off its input.
   task automatic test_backpressure();
      long_hold_request = 1'b1;
      repeat (120) begin
         frame_bytes.delete();
         add_junk($urandom_range(0, 2), CHAR_NUL);
         send_frame(1'b0);
      end
      drain_results();
   endtask

   // The sender goes quiet until every mask has arrived, then resumes.
   task automatic test_sender_pause();
      write_mode(MODE_TAGS);
      repeat (3) begin
         repeat (4) begin
            frame_bytes.delete();
            build_frame_for_mode();
            send_frame($urandom_range(0, 3) == 0);
         end
         drain_results();
      end
   endtask

   task automatic test_random_traffic();
      logic [7:0] mode_plan;
      int         stop_at;
      mode_plan = {MODE_TAGS, MODE_STATUS, MODE_STATUS, MODE_TAGS,
                   MODE_TAGS, MODE_STATUS, MODE_TAGS, MODE_STATUS};
      for (int ph = 0; ph < 8; ph++) begin
         write_mode(mode_plan[ph]);
         steady_sender = (ph == 3 || ph == 6);
         stop_at = words_sent + 100;
         while (words_sent < stop_at) begin
            frame_bytes.delete();
            if ($urandom_range(0, 6) == 0)
               build_noise_frame();
            else
               build_frame_for_mode();
            send_frame($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 40) == 0)
               drain_results();
         end
      end
      steady_sender = 1'b0;
   endtask

   // ---------------------------------------------------------------------------
   // Receiver, checker and watchdog
   // ---------------------------------------------------------------------------

   // The receiver picks a readiness style for a run of cycles. A request from a test
   // makes it hold tready low for a long stretch counted here.
   initial begin : rsp_ready_pattern
      ready_style_type style;
      int              run_len;
      int              k;
      forever begin
         style   = ready_style_type'($urandom_range(0, 3));
         run_len = $urandom_range(4, 60);
         k = 0;
         while (k < run_len && !long_hold_request) begin
            case (style)
               READY_ALWAYS:   rsp_tready <= 1'b1;
               READY_HALF:     rsp_tready <= ($urandom_range(0, 1) == 1);
               READY_MOSTLY:   rsp_tready <= ($urandom_range(0, 4) != 0);
               READY_PERIODIC: rsp_tready <= (k % 4 == 0);
            endcase
            @(posedge clock);
            k++;
         end
         if (long_hold_request) begin
            long_hold_request = 1'b0;
            rsp_tready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
         end
      end
   end

   // Every mask taken from rsp_ is compared with the oldest one owed.
   always @(posedge clock) begin : check_masks
      logic [7:0] want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_masks.size() == 0) begin
            $error("relay_mask: no word expected, actual %02h", rsp_tdata);
            fail_count++;
         end else begin
            want = expected_masks.pop_front();
            if (rsp_tdata !== want) begin
               $error("relay_mask: expected %02h, actual %02h", want, rsp_tdata);
               fail_count++;
            end
         end
      end
   end

   // Ends the run when neither channel has moved a word for too long.
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("relay_status_response_scanner: mismatch");
         $finish;
      end
   end

   // ---------------------------------------------------------------------------
   // Sequence
   // ---------------------------------------------------------------------------

   initial begin
      board_mode_now = MODE_STATUS;
      clear_scan_state();
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      test_status_lines();
      test_relay_tags();
      test_mode_write_drops_scan();
      test_backpressure();
      test_sender_pause();
      test_random_traffic();
      drain_results();

      if (fail_count == 0)
         $display("relay_status_response_scanner: match");
      else
         $display("relay_status_response_scanner: mismatch");
      $finish;
   end

endmodule

@@ filelist.f @@
rtl/rss_pkg.sv
rtl/rss_core.sv
rtl/relay_status_response_scanner.sv
dv/tb_relay_status_response_scanner.sv
